// File: hdl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life grid generation step core.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

    // Port field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int CELLS_W = 16;

    // Neighbor count: up to eight live neighbors
    localparam int NBR_W = 4;

    // Rule constants
    localparam logic [NBR_W-1:0] LIVE_KEEP  = NBR_W'(2);
    localparam logic [NBR_W-1:0] LIVE_BIRTH = NBR_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

endpackage

`default_nettype wire

// File: hdl/lgs_row_cell.sv
// ----------------------------------------------------------------------------
// lgs_row_cell
// One link of the row chain: holds one grid row, takes its neighbor's row
// on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_cell #(
    parameter int WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire logic [WIDTH-1:0] i_row,
    output logic      [WIDTH-1:0] o_row
);

    logic [WIDTH-1:0] r_row;
    logic [WIDTH-1:0] n_row;

    // Advance on shift, hold otherwise
    always_comb begin
        n_row = i_shift ? i_row : r_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

// File: hdl/lgs_rule.sv
// ----------------------------------------------------------------------------
// lgs_rule
// Next generation of one row from the rows above, itself and below.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_rule
    import lgs_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  wire logic [WIDTH-1:0] i_above,
    input  wire logic [WIDTH-1:0] i_row,
    input  wire logic [WIDTH-1:0] i_below,
    output logic      [WIDTH-1:0] o_row
);

    // Pad a dead column on each side; column c sits at padded index c+1
    logic [WIDTH+1:0] w_a;
    logic [WIDTH+1:0] w_m;
    logic [WIDTH+1:0] w_b;

    assign w_a = {1'b0, i_above, 1'b0};
    assign w_m = {1'b0, i_row,   1'b0};
    assign w_b = {1'b0, i_below, 1'b0};

    for (genvar c = 0; c < WIDTH; c++) begin : g_col
        logic [NBR_W-1:0] w_cnt;

        assign w_cnt = NBR_W'(w_a[c]) + NBR_W'(w_a[c+1]) + NBR_W'(w_a[c+2])
                     + NBR_W'(w_m[c])                    + NBR_W'(w_m[c+2])
                     + NBR_W'(w_b[c]) + NBR_W'(w_b[c+1]) + NBR_W'(w_b[c+2]);

        assign o_row[c] = (w_cnt == LIVE_BIRTH) || (i_row[c] && (w_cnt == LIVE_KEEP));
    end

endmodule

`default_nettype wire

// File: hdl/life_grid_generation_step_core.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step_core
// A new item is taken only after the sweep of the last one has ended; every
// command makes one full rotation of the HEIGHT-long row chain, one row per
// cycle past the rule unit.
// A stalled result holds the sweep on its last row until the slot frees.
// Reset: synchronous, active low; clears the grid to dead, drops any item.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step_core
    import lgs_pkg::*;
#(
    parameter int WIDTH  = 16,
    parameter int HEIGHT = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [IDX_W-1:0]   i_row_index,
    input  wire logic [CELLS_W-1:0] i_row_cells,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [CELLS_W-1:0]      o_row_value,
    output logic                    o_was_read
);

    // Sweep counter: it also names the row that sits in the head cell
    localparam int CNT_W     = $clog2(HEIGHT);
    localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEIGHT - 1);

    // ------------------------------------------------------------------
    // Control and item registers
    // ------------------------------------------------------------------
    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic [CELLS_W-1:0] r_wr_cells;
    logic [WIDTH-1:0]   r_rd_val;
    logic [WIDTH-1:0]   r_prev;

    logic               r_out_valid;
    logic [CELLS_W-1:0] r_row_value;
    logic               r_was_read;

    logic               w_accept;
    logic               w_last;
    logic               w_adv;
    logic               w_hit;
    logic [WIDTH-1:0]   w_wr_row;
    logic [WIDTH-1:0]   w_below;
    logic [WIDTH-1:0]   w_new_row;
    logic [WIDTH-1:0]   w_tail;
    logic [WIDTH-1:0]   n_rd_val;
    logic [CELLS_W-1:0] w_rd_out;

    logic [WIDTH-1:0]   w_rows [HEIGHT];

    // Take a new item only while no sweep runs
    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;

    assign w_last = (r_cnt == CNT_LAST);

    // Hold the whole chain on the final cycle while the result slot is
    // still full and stalled downstream
    assign w_adv = r_busy && !(w_last && r_out_valid && i_out_stall);

    // Row index beyond the grid never matches the counter
    assign w_hit = (CMP_W'(r_idx) == CMP_W'(r_cnt));

    // Fit the port row to the grid width: drop or zero-fill columns
    for (genvar c = 0; c < WIDTH; c++) begin : g_wr_map
        if (c < CELLS_W) begin : g_in
            assign w_wr_row[c] = r_wr_cells[c];
        end else begin : g_zero
            assign w_wr_row[c] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Row chain: cell k hands its row to cell k-1 on each advance; the
    // head row leaves cell 0 and the tail cell takes the processed row
    // ------------------------------------------------------------------
    for (genvar k = 0; k < HEIGHT; k++) begin : g_chain
        logic [WIDTH-1:0] w_feed;

        if (k == HEIGHT - 1) begin : g_tail
            assign w_feed = w_tail;
        end else begin : g_link
            assign w_feed = w_rows[k+1];
        end

        lgs_row_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_adv),
            .i_row   (w_feed),
            .o_row   (w_rows[k])
        );
    end

    // During a step cell 1 still holds the old row below the head, except
    // on the last row where new row 0 has wrapped around: treat as dead
    assign w_below = w_last ? '0 : w_rows[1];

    lgs_rule #(
        .WIDTH (WIDTH)
    ) u_rule (
        .i_above (r_prev),
        .i_row   (w_rows[0]),
        .i_below (w_below),
        .o_row   (w_new_row)
    );

    // Pick what re-enters the chain at the tail
    always_comb begin
        w_tail   = w_rows[0];
        n_rd_val = r_rd_val;
        case (r_cmd)
            CMD_WRITE: begin
                if (w_hit) begin
                    w_tail = w_wr_row;
                end
            end
            CMD_STEP: begin
                w_tail = w_new_row;
            end
            CMD_READ: begin
                if (w_hit) begin
                    n_rd_val = w_rows[0];
                end
            end
            default: begin
                w_tail = w_rows[0];
            end
        endcase
    end

    // Fit the grid row back to the port width
    for (genvar b = 0; b < CELLS_W; b++) begin : g_rd_map
        if (b < WIDTH) begin : g_out
            assign w_rd_out[b] = n_rd_val[b];
        end else begin : g_zero
            assign w_rd_out[b] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_adv) begin
            r_busy <= !w_last;
            r_cnt  <= w_last ? '0 : r_cnt + 1'b1;
        end
    end

    // Item payload; the above-row register starts dead for row 0
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_idx      <= i_row_index;
            r_wr_cells <= i_row_cells;
            r_rd_val   <= '0;
            r_prev     <= '0;
        end else if (w_adv) begin
            r_rd_val   <= n_rd_val;
            r_prev     <= w_rows[0];
        end
    end

    // Result register: load at the end of a sweep, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last) begin
            r_row_value <= w_rd_out;
            r_was_read  <= (r_cmd == CMD_READ);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_value = r_row_value;
    assign o_was_read  = r_was_read;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_sweep : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && r_cnt == '0)
    ) else $error("accepted item did not start a sweep");

    a_counter_advances : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_last) |=> (r_busy && r_cnt == CNT_W'($past(r_cnt) + 1'b1))
    ) else $error("sweep counter skipped or stopped");

    a_result_at_sweep_end : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && w_last)
    ) else $error("result loaded outside the last sweep cycle");

    a_nonread_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_was_read) |-> (r_row_value == '0)
    ) else $error("non-read result carries row data");

    a_held_chain_when_full : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_last && r_out_valid && i_out_stall) |=> (r_busy && w_last)
    ) else $error("sweep finished while result slot was blocked");

endmodule

`default_nettype wire

// File: sim/tb_life_grid_generation_step_core.sv
// ----------------------------------------------------------------------------
// tb_life_grid_generation_step_core
// Self-checking bench for the bounded Game of Life core. A shadow copy of
// the grid is updated for every accepted item, and each result is compared
// field by field against the oldest predicted one. Directed tests cover
// reset contents, row and cell extremes, the unused command and the grid
// edges. Random life sequences (load, advance, read back) follow, mixed
// with noise items, under random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_life_grid_generation_step_core;
    import lgs_pkg::*;

    localparam int WIDTH  = 16;
    localparam int HEIGHT = 16;

    // Random part length and run limits
    localparam int RANDOM_ITEMS   = 1880;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_LIMIT      = 8000;

    // Cells beyond the grid width never hold a live cell
    localparam logic [CELLS_W-1:0] ROW_MASK = {CELLS_W{1'b1}} >> (CELLS_W - WIDTH);

    // Unused command code; the package names only the three real commands
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CELLS_W-1:0] row_value;
        logic               was_read;
    } t_row_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_cmd;
    logic [IDX_W-1:0]   i_row_index;
    logic [CELLS_W-1:0] i_row_cells;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [CELLS_W-1:0] o_row_value;
    logic               o_was_read;

    // Shadow grid and the queue of results it predicts
    logic [CELLS_W-1:0] shadow_grid [HEIGHT];
    t_row_result        row_result_q [$];

    int error_count     = 0;
    int results_checked = 0;
    int random_items    = 0;
    int writes_sent     = 0;
    int steps_sent      = 0;
    int reads_sent      = 0;
    int unused_sent     = 0;
    int no_gap_left     = 0;
    int idle_cycles     = 0;

    life_grid_generation_step_core #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_row_index (i_row_index),
        .i_row_cells (i_row_cells),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_row_value (o_row_value),
        .o_was_read  (o_was_read)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Cells outside the grid count as dead: no wrap-around at any edge
    function automatic bit cell_at(int r, int c);
        if (r < 0 || r >= HEIGHT || c < 0 || c >= WIDTH)
            return 1'b0;
        return shadow_grid[r][c];
    endfunction

    // Advance the shadow grid one generation from a frozen copy
    task automatic advance_shadow_grid();
        logic [CELLS_W-1:0] gen_rows [HEIGHT];
        int nbrs;
        for (int r = 0; r < HEIGHT; r++) begin
            gen_rows[r] = '0;
            for (int c = 0; c < WIDTH; c++) begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            nbrs += cell_at(r + dr, c + dc);
                // Survive on two or three neighbors, birth on exactly three
                if (cell_at(r, c))
                    gen_rows[r][c] = (nbrs == LIVE_KEEP) || (nbrs == LIVE_BIRTH);
                else
                    gen_rows[r][c] = (nbrs == LIVE_BIRTH);
            end
        end
        for (int r = 0; r < HEIGHT; r++)
            shadow_grid[r] = gen_rows[r] & ROW_MASK;
    endtask

    // Apply one accepted item to the shadow grid and queue its result
    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic [IDX_W-1:0] idx,
                                 input logic [CELLS_W-1:0] cells);
        t_row_result res;
        res = '0;
        case (cmd)
            CMD_WRITE: begin
                writes_sent++;
                if (int'(idx) < HEIGHT)
                    shadow_grid[idx] = cells & ROW_MASK;
            end
            CMD_STEP: begin
                steps_sent++;
                advance_shadow_grid();
            end
            CMD_READ: begin
                reads_sent++;
                res.was_read = 1'b1;
                if (int'(idx) < HEIGHT)
                    res.row_value = shadow_grid[idx] & ROW_MASK;
            end
            default: begin
                // Unused code: grid holds, result is all zero
                unused_sent++;
            end
        endcase
        row_result_q.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones, and now and then a run of none
    function automatic int pick_gap();
        int r;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            no_gap_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one item at the falling edge and hold it until accepted
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [IDX_W-1:0] idx,
                             input logic [CELLS_W-1:0] cells);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd       = cmd;
        i_row_index = idx;
        i_row_cells = cells;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        apply_command(cmd, idx, cells);
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (row_result_q.size() != 0) @(posedge i_clk);
    endtask

    // Row contents of varied density, extremes included
    function automatic logic [CELLS_W-1:0] random_cells();
        case ($urandom_range(0, 5))
            0:       return CELLS_W'($urandom & $urandom & $urandom);
            1:       return CELLS_W'($urandom & $urandom);
            2:       return CELLS_W'($urandom);
            3:       return CELLS_W'(~($urandom & $urandom));
            4:       return '0;
            default: return '1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall pattern, changed at the falling edge
    // ------------------------------------------------------------------------
    initial begin : stall_gen
        int stall_left;
        int free_left;
        stall_left  = 0;
        free_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                i_out_stall = 1'b0;
                free_left--;
            end else begin
                // Pick the next free stretch and the stall that follows it
                free_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(0, 6);
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
                i_out_stall = 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_row_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (row_result_q.size() == 0) begin
                $error("result with no prediction pending: row_value=%h was_read=%b",
                       o_row_value, o_was_read);
                error_count++;
            end else begin
                exp_res = row_result_q.pop_front();
                results_checked++;
                if (o_row_value !== exp_res.row_value) begin
                    $error("row_value mismatch: expected %h, actual %h",
                           exp_res.row_value, o_row_value);
                    error_count++;
                end
                if (o_was_read !== exp_res.was_read) begin
                    $error("was_read mismatch: expected %b, actual %b",
                           exp_res.was_read, o_was_read);
                    error_count++;
                end
            end
        end
    end

    // Stop the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Read both end rows straight after reset: all cells dead
    task automatic test_reset_state();
        send_item(CMD_READ, 4'd0, '1);
        send_item(CMD_READ, 4'(HEIGHT - 1), '0);
    endtask

    // Load and read back the extreme rows and cell patterns
    task automatic test_row_extremes();
        send_item(CMD_WRITE, 4'd0, '1);
        send_item(CMD_WRITE, 4'(HEIGHT - 1), 16'h8001);
        send_item(CMD_WRITE, 4'd7, '0);
        send_item(CMD_READ, 4'd0, '0);
        send_item(CMD_READ, 4'(HEIGHT - 1), '1);
        send_item(CMD_READ, 4'd7, 16'h5a5a);
    endtask

    // The unused code leaves the grid alone and answers with zeros
    task automatic test_unused_cmd();
        send_item(CMD_UNUSED, 4'd0, '0);
        send_item(CMD_UNUSED, 4'(HEIGHT - 1), '1);
        send_item(CMD_READ, 4'd0, '0);
    endtask

    // Advance with live cells on the top row and bottom corners; a wrapped
    // neighborhood would bleed between rows 0 and HEIGHT-1
    task automatic test_edges_no_wrap();
        send_item(CMD_STEP, 4'(HEIGHT - 1), '1);
        send_item(CMD_READ, 4'd0, '0);
        send_item(CMD_READ, 4'd1, '0);
        send_item(CMD_READ, 4'(HEIGHT - 2), '0);
        send_item(CMD_READ, 4'(HEIGHT - 1), '0);
        send_item(CMD_STEP, 4'd0, '0);
        send_item(CMD_READ, 4'd0, '0);
        send_item(CMD_READ, 4'd1, '0);
    endtask

    // Hold the sender until the block has answered everything
    task automatic test_drain_pause();
        drain_results();
        send_item(CMD_READ, 4'd1, '0);
        drain_results();
    endtask

    // Life sequences with random content, broken up by noise items
    task automatic test_random_life();
        int n_rows;
        int n_steps;
        int n_reads;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                // Load: sometimes the whole grid in order, else scattered rows
                if ($urandom_range(0, 3) == 0) begin
                    for (int r = 0; r < HEIGHT; r++)
                        send_item(CMD_WRITE, 4'(r), random_cells());
                    random_items += HEIGHT;
                end else begin
                    n_rows = $urandom_range(1, HEIGHT);
                    repeat (n_rows)
                        send_item(CMD_WRITE, 4'($urandom_range(0, HEIGHT - 1)),
                                  random_cells());
                    random_items += n_rows;
                end
                // Advance a few generations, peeking at rows in between
                n_steps = $urandom_range(1, 4);
                repeat (n_steps) begin
                    send_item(CMD_STEP, 4'($urandom), CELLS_W'($urandom));
                    n_reads = $urandom_range(0, 4);
                    repeat (n_reads)
                        send_item(CMD_READ, 4'($urandom_range(0, HEIGHT - 1)),
                                  CELLS_W'($urandom));
                    random_items += 1 + n_reads;
                end
                // Read the whole grid back now and then
                if ($urandom_range(0, 2) == 0) begin
                    for (int r = 0; r < HEIGHT; r++)
                        send_item(CMD_READ, 4'(r), CELLS_W'($urandom));
                    random_items += HEIGHT;
                end
            end else begin
                n_rows = $urandom_range(1, 6);
                repeat (n_rows)
                    send_item(CMD_WRITE + 2'($urandom_range(0, 3)), 4'($urandom),
                              CELLS_W'($urandom));
                random_items += n_rows;
            end
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int waited;
        for (int r = 0; r < HEIGHT; r++)
            shadow_grid[r] = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_WRITE;
        i_row_index = '0;
        i_row_cells = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_row_extremes();
        test_unused_cmd();
        test_edges_no_wrap();
        test_drain_pause();
        test_random_life();

        // Drop valid, wait out pending results, then idle on before the report
        @(negedge i_clk);
        i_in_valid = 1'b0;
        waited = 0;
        while (row_result_q.size() != 0 && waited < END_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (row_result_q.size() != 0) begin
            $error("%0d predicted results never arrived", row_result_q.size());
            error_count++;
        end
        repeat (2 * (HEIGHT + 1)) @(posedge i_clk);

        $display("Checked %0d results from %0d writes, %0d generation steps,",
                 results_checked, writes_sent, steps_sent);
        $display("%0d row reads and %0d unused commands under random gaps and stalls.",
                 reads_sent, unused_sent);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
